FILE: src/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_pkg
// Shared constants, codes and the hex font of the scrolling seven-segment
// scanner.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int DIGITS       = 6;
    localparam int BUFFER_CHARS = 16;
    localparam int MAX_OFFSET   = 10;

    localparam int POS_W     = 5;
    localparam int CODE_W    = 8;
    localparam int SEG_W     = 7;
    localparam int PERIOD_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam int ADDR_W   = (BUFFER_CHARS > 1) ? $clog2(BUFFER_CHARS) : 1;
    localparam int RIDX_W   = $clog2(BUFFER_CHARS + 1);
    localparam int OFFS_W   = (MAX_OFFSET > 0) ? $clog2(MAX_OFFSET + 1) : 1;
    localparam int SCAN_W   = $clog2(DIGITS + 1);

    localparam logic [SEG_W-1:0]  BLANK_SEGS = 7'h7F;
    localparam logic [CODE_W-1:0] BLANK_CODE = 8'hFF;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCROLL_ENABLE = 1'b0,
        REG_SCROLL_PERIOD = 1'b1
    } t_reg_idx;

    // Active-low a..g pattern of a character code; codes above 15 are blank.
    function automatic logic [SEG_W-1:0] glyph_of(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] segs;
        segs = BLANK_SEGS;
        if (code[CODE_W-1:4] == '0) begin
            unique case (code[3:0])
                4'h0: segs = 7'h40;
                4'h1: segs = 7'h79;
                4'h2: segs = 7'h24;
                4'h3: segs = 7'h30;
                4'h4: segs = 7'h19;
                4'h5: segs = 7'h12;
                4'h6: segs = 7'h02;
                4'h7: segs = 7'h78;
                4'h8: segs = 7'h00;
                4'h9: segs = 7'h18;
                4'hA: segs = 7'h08;
                4'hB: segs = 7'h03;
                4'hC: segs = 7'h27;
                4'hD: segs = 7'h21;
                4'hE: segs = 7'h06;
                4'hF: segs = 7'h0E;
            endcase
        end
        return segs;
    endfunction

endpackage

FILE: src/sss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sss_if
// Valid/ready channels of the scanner: command items in, digit drives out.
// ----------------------------------------------------------------------------
interface sss_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [sss_pkg::POS_W-1:0]    position;
    logic [sss_pkg::CODE_W-1:0]   char_code;

    modport source (output valid, output command, output position,
                    output char_code, input ready);
    modport sink   (input valid, input command, input position,
                    input char_code, output ready);
endinterface

interface sss_out_if;
    logic                         valid;
    logic                         ready;
    logic [sss_pkg::DIGITS-1:0]   common_select;
    logic [sss_pkg::SEG_W-1:0]    segments;
    logic                         point;

    modport source (output valid, output common_select, output segments,
                    output point, input ready);
    modport sink   (input valid, input common_select, input segments,
                    input point, output ready);
endinterface

FILE: src/scrolling_seven_segment_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_seven_segment_scanner
// Multiplexed seven-segment driver with a scrolling character buffer.
// ----------------------------------------------------------------------------
// Input channel i_in carries one command per transaction: a write of a
// character code at a 1-based buffer position, or a refresh tick. A write
// gives no result; each tick gives one transaction on o_out with the
// active-low digit select, the active-low segments and the point (off).
// Configuration writes (scroll enable, scroll period) go through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must make them only while the block
// is idle; the block itself does not enforce it. Throughput is one
// transaction per cycle unless o_out stalls. A tick reads the character
// memory into the read stage, then the font lookup fills the output register.
// Reset clears the scan, scroll counters and configuration at once and marks
// every buffer entry as blank through per-entry valid bits; no sweep.
// When the receiver stalls, the output register holds its result and the
// read stage behind it fills; i_in.ready drops once both are full and
// returns in the cycle o_out.ready rises.
// ----------------------------------------------------------------------------
module scrolling_seven_segment_scanner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sss_in_if.sink                        i_in,
    sss_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sss_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int BC = sss_pkg::BUFFER_CHARS;

    // configuration
    logic                          r_scroll_enable;
    logic [sss_pkg::PERIOD_W-1:0]  r_scroll_period;

    // scan state
    logic [sss_pkg::SCAN_W-1:0]    r_scan_digit,    n_scan_digit;
    logic [sss_pkg::PERIOD_W-1:0]  r_scroll_delay,  n_scroll_delay;
    logic [sss_pkg::OFFS_W-1:0]    r_scroll_offset, n_scroll_offset;
    logic [sss_pkg::RIDX_W-1:0]    r_read_index,    n_read_index;

    // character memory and its entry valid bits
    logic [sss_pkg::CODE_W-1:0]    r_mem [BC];
    logic [BC-1:0]                 r_entry_valid;
    logic [sss_pkg::CODE_W-1:0]    r_rd_data;
    logic                          r_rd_valid;

    // read stage and output stage
    logic                          r_s1_valid;
    logic                          r_s1_in_range;
    logic [sss_pkg::DIGITS-1:0]    r_s1_select;
    logic                          r_s2_valid;
    logic [sss_pkg::DIGITS-1:0]    r_s2_select;
    logic [sss_pkg::SEG_W-1:0]     r_s2_segments;

    logic                          s1_ready, s2_ready;
    logic                          accept, tick, wr_en;
    logic [sss_pkg::ADDR_W-1:0]    wr_addr;
    logic [sss_pkg::PERIOD_W-1:0]  delay_inc;
    logic [sss_pkg::RIDX_W-1:0]    frame_index;
    logic                          in_range;
    logic [sss_pkg::DIGITS-1:0]    select;
    logic [sss_pkg::SEG_W-1:0]     s1_segments;

    assign s2_ready   = !r_s2_valid || o_out.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign i_in.ready = s1_ready;
    assign accept     = i_in.valid && s1_ready;
    assign tick       = accept && (i_in.command == sss_pkg::CMD_TICK);

    assign wr_en   = accept && (i_in.command == sss_pkg::CMD_WRITE)
                     && (i_in.position != '0)
                     && (i_in.position <= sss_pkg::POS_W'(BC));
    assign wr_addr = sss_pkg::ADDR_W'(i_in.position - sss_pkg::POS_W'(1));

    // scroll and scan update of one tick
    always_comb begin
        n_scroll_delay  = r_scroll_delay;
        n_scroll_offset = r_scroll_offset;
        delay_inc       = r_scroll_delay + sss_pkg::PERIOD_W'(1);
        if (r_scroll_enable) begin
            n_scroll_delay = delay_inc;
            if (delay_inc == r_scroll_period) begin
                n_scroll_delay = '0;
                if (r_scroll_offset >= sss_pkg::OFFS_W'(sss_pkg::MAX_OFFSET)) begin
                    n_scroll_offset = '0;
                end else begin
                    n_scroll_offset = r_scroll_offset + sss_pkg::OFFS_W'(1);
                end
            end
        end

        frame_index = r_read_index;
        if (r_scan_digit >= sss_pkg::SCAN_W'(sss_pkg::DIGITS)) begin
            n_scan_digit = sss_pkg::SCAN_W'(1);
            frame_index  = sss_pkg::RIDX_W'(n_scroll_offset);
        end else begin
            n_scan_digit = r_scan_digit + sss_pkg::SCAN_W'(1);
        end

        in_range     = frame_index < sss_pkg::RIDX_W'(BC);
        n_read_index = in_range ? frame_index + sss_pkg::RIDX_W'(1) : frame_index;
        select       = ~(sss_pkg::DIGITS'(1) << (n_scan_digit - sss_pkg::SCAN_W'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_enable <= 1'b0;
            r_scroll_period <= '0;
        end else if (i_cfg_we) begin
            unique case (sss_pkg::t_reg_idx'(i_cfg_index))
                sss_pkg::REG_SCROLL_ENABLE: r_scroll_enable <= i_cfg_data[0];
                sss_pkg::REG_SCROLL_PERIOD:
                    r_scroll_period <= i_cfg_data[sss_pkg::PERIOD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_digit    <= '0;
            r_scroll_delay  <= '0;
            r_scroll_offset <= '0;
            r_read_index    <= '0;
        end else if (tick) begin
            r_scan_digit    <= n_scan_digit;
            r_scroll_delay  <= n_scroll_delay;
            r_scroll_offset <= n_scroll_offset;
            r_read_index    <= n_read_index;
        end
    end

    // character memory: one write or one read per cycle, never both
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_in.char_code;
        end
        if (tick) begin
            r_rd_data <= r_mem[frame_index[sss_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_valid    <= 1'b0;
        end else begin
            if (wr_en) begin
                r_entry_valid[wr_addr] <= 1'b1;
            end
            if (tick) begin
                r_rd_valid <= r_entry_valid[frame_index[sss_pkg::ADDR_W-1:0]];
            end
        end
    end

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_s1_in_range <= in_range;
            r_s1_select   <= select;
        end
    end

    // unwritten entries read as the blank code
    assign s1_segments = !r_s1_in_range ? sss_pkg::BLANK_SEGS
                       : sss_pkg::glyph_of(r_rd_valid ? r_rd_data : sss_pkg::BLANK_CODE);

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_select   <= r_s1_select;
            r_s2_segments <= s1_segments;
        end
    end

    assign o_out.valid         = r_s2_valid;
    assign o_out.common_select = r_s2_select;
    assign o_out.segments      = r_s2_segments;
    assign o_out.point         = 1'b1;

    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $onehot(~o_out.common_select))
        else $error("digit select is not one-hot active-low");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scroll_offset <= sss_pkg::OFFS_W'(sss_pkg::MAX_OFFSET))
        else $error("scroll offset past its maximum");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_index <= sss_pkg::RIDX_W'(BC))
        else $error("read index past the buffer end");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !o_out.ready && r_s1_valid) |-> !i_in.ready)
        else $error("input accepted with both stages full");

endmodule
